>>> rtl/core/pas_pkg.sv
// Shared widths, codes and types for the pitot airspeed unit.
// Used by the channel interfaces, the serial divider, the serial root and the top level.
// No dependencies.
package pas_pkg;

  // Converter resolution and the widths of the interface fields.
  localparam int ADC_BITS = 12;
  localparam int CODE_W   = ADC_BITS;
  localparam int PA_W     = 18;
  localparam int DEN_W    = 12;
  localparam int CNT_W    = 10;
  localparam int SPD_W    = 24;
  localparam int DP_W     = 25;
  localparam int ST_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = PA_W;

  // Running calibration sum.
  localparam int SUM_W = 35;

  // Serial multiplier: (10*code - full scale) times (p_max - p_min).
  localparam int A_W     = ADC_BITS + 5;
  localparam int B_W     = PA_W + 1;
  localparam int HI_W    = B_W + 1;
  localparam int MS_W    = HI_W + 1;
  localparam int P_W     = HI_W + A_W;
  localparam int MCNT_W  = $clog2(A_W);
  localparam int SHR_W   = P_W - ADC_BITS + 2;
  localparam int P_Q4_W  = 26;
  localparam int DIFF_W  = DP_W + 2;

  // Speed scaling, divider and root widths.
  localparam int SPD_FRAC  = 23;
  localparam int DIV_W     = DP_W + SPD_FRAC;
  localparam int DVS_W     = DEN_W;
  localparam int DCNT_W    = $clog2(DIV_W);
  localparam int SQ_IN_W   = 2 * (SPD_W - 1);
  localparam int SQ_R_W    = SPD_W - 1;
  localparam int SQ_REM_W  = SQ_R_W + 2;
  localparam int SCNT_W    = $clog2(SQ_R_W);

  // Saturation limits.
  localparam int DP_MAX  = (1 << (DP_W - 1)) - 1;
  localparam int DP_MIN  = -(1 << (DP_W - 1));
  localparam int SPD_MAX = (1 << (SPD_W - 1)) - 1;

  // Register reset values.
  localparam int P_MIN_RST = -2000;
  localparam int P_MAX_RST = 2000;
  localparam int DEN_RST   = 1254;
  localparam int CNT_RST   = 400;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_MEASURED     = 2'd0,
    ST_CAL_SAMPLE   = 2'd1,
    ST_BIAS_LATCHED = 2'd2,
    ST_ZERO_REF     = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_MIN   = 2'd0,
    REG_P_MAX   = 2'd1,
    REG_DENSITY = 2'd2,
    REG_CAL_CNT = 2'd3
  } cfg_reg_e;

endpackage

>>> rtl/core/pas_if.sv
// Valid/ready channel interfaces of the pitot airspeed unit: samples, results, configuration.
// Depends on pas_pkg for the field widths.

// Sample channel: one ADC pair per beat.
interface pas_in_if;
  import pas_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CODE_W-1:0] ref_code;
  logic [CODE_W-1:0] sensor_code;
  modport source (output valid, mode, ref_code, sensor_code, input ready);
  modport sink   (input valid, mode, ref_code, sensor_code, output ready);
endinterface

// Result channel: one result per beat.
interface pas_out_if;
  import pas_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SPD_W-1:0] air_speed_q8;
  logic signed [DP_W-1:0]  diff_pressure_q4;
  logic [ST_W-1:0]        status;
  modport source (output valid, air_speed_q8, diff_pressure_q4, status, input ready);
  modport sink   (input valid, air_speed_q8, diff_pressure_q4, status, output ready);
endinterface

// Configuration write channel: register index and data per beat.
interface pas_cfg_if;
  import pas_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/pas_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, for the pitot airspeed unit.
// Depends on pas_pkg for the dividend and divisor widths.
module pas_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pas_pkg::DIV_W-1:0] dividend_i,
  input  logic [pas_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [pas_pkg::DIV_W-1:0] quotient_o
);
  import pas_pkg::*;

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVS_W:0]    rem2, rem_sub;
  logic              ge;

  // Bring in the next dividend bit and try the subtraction.
  assign rem2    = {rem_q, dvd_q[DIV_W-1]};
  assign ge      = rem2 >= {1'b0, dvs_q};
  assign rem_sub = rem2 - {1'b0, dvs_q};

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the dividend register as it empties.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_sub[DVS_W-1:0] : rem2[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

>>> rtl/core/pas_sqrt.sv
// Bit-serial integer square root, one root bit per cycle, for the pitot airspeed unit.
// Depends on pas_pkg for the operand and root widths.
module pas_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pas_pkg::SQ_IN_W-1:0] radicand_i,
  output logic                        done_o,
  output logic [pas_pkg::SQ_R_W-1:0]  root_o
);
  import pas_pkg::*;

  logic                busy_q, done_q;
  logic [SCNT_W-1:0]   cnt_q;
  logic [SQ_IN_W-1:0]  x_q;
  logic [SQ_R_W-1:0]   root_q;
  logic [SQ_REM_W-1:0] rem_q;
  logic [SQ_REM_W+1:0] rem2, trial, rem_sub;
  logic                ge;

  // Two radicand bits per step against the trial value 4*root + 1.
  assign rem2    = {rem_q, x_q[SQ_IN_W-1 -: 2]};
  assign trial   = (SQ_REM_W + 2)'({root_q, 2'b01});
  assign ge      = rem2 >= trial;
  assign rem_sub = rem2 - trial;

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SCNT_W'(SQ_R_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Root and partial remainder datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      root_q <= {root_q[SQ_R_W-2:0], ge};
      rem_q  <= ge ? rem_sub[SQ_REM_W-1:0] : rem2[SQ_REM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/core/pitot_airspeed_from_adc_unit.sv
// Top level of the pitot airspeed unit: sample conversion, bias calibration and speed.
// Depends on pas_pkg, the channel interfaces, pas_div and pas_sqrt.
//
// One sample is taken at a time and gives exactly one result. A zero reference code goes from
// the result registers straight to the output register. Any other sample first goes through
// the bit-serial multiplier and a rounding step; a calibration sample that only adds to the
// running sum then goes through the result registers to the output register. The sample that
// completes a calibration run also goes through the serial divider for the mean. A measurement
// runs the divider for |dp| * 2^23 / density and then the serial square root, or saturates
// the speed if the quotient is too wide for the root. A new sample is accepted as soon as
// the previous one has been handed to the output register, even while that result waits
// to be taken.
module pitot_airspeed_from_adc_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pas_in_if.sink     in_i,
  pas_out_if.source  out_o,
  pas_cfg_if.sink    cfg_i
);
  import pas_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_ROUND = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_PREP  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_SQRT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  // Configuration registers.
  logic signed [PA_W-1:0] p_min_q, p_max_q;
  logic [DEN_W-1:0]       density_q;
  logic [CNT_W-1:0]       cal_cnt_cfg_q;

  // Control state.
  state_e                  state_q, state_d;
  logic [MCNT_W-1:0]       mcnt_q, mcnt_d;
  logic signed [DP_W-1:0]  bias_q, bias_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;

  // Datapath registers.
  logic                     mode_q, mode_d;
  logic [A_W-1:0]           lo_q, lo_d;
  logic signed [HI_W-1:0]   hi_q, hi_d;
  logic signed [B_W-1:0]    b_q, b_d;
  logic signed [P_Q4_W-1:0] p_q, p_d;
  logic                     sign_q, sign_d;
  logic signed [SPD_W-1:0]  res_speed_q, res_speed_d;
  logic signed [DP_W-1:0]   res_dp_q, res_dp_d;
  status_e                  res_status_q, res_status_d;
  logic signed [SPD_W-1:0]  out_speed_q, out_speed_d;
  logic signed [DP_W-1:0]   out_dp_q, out_dp_d;
  status_e                  out_status_q, out_status_d;

  // Unit handshakes.
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quotient;
  logic [DVS_W-1:0]   div_divisor;
  logic               sqrt_start, sqrt_done;
  logic [SQ_R_W-1:0]  sqrt_root;

  // Sample conversion terms.
  logic [A_W-1:0]           code_ext, a_init;
  logic signed [B_W-1:0]    b_init;
  logic signed [HI_W:0]     b_ext, addend, msum;
  logic                     mlast;
  logic signed [P_W-1:0]    prod;
  logic [SHR_W-1:0]         rnd;
  logic signed [SHR_W-2:0]  rnd_half;
  logic signed [P_Q4_W-1:0] p_new;

  // Calibration and measurement terms.
  logic signed [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]         cnt_new, cal_target;
  logic                     cal_latch;
  logic [SUM_W-1:0]         sum_mag;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DP_W-1:0]   dp_sat, bias_new, q_cut;
  logic [DP_W-1:0]          dp_mag;
  logic [DVS_W-1:0]         density_eff;
  logic signed [SPD_W-1:0]  root_ext;
  logic                     in_beat;

  assign in_beat = in_i.valid && in_i.ready;

  // Multiplier operands: 10*code - full scale, and the pressure span.
  assign code_ext = A_W'(in_i.sensor_code);
  assign a_init   = (code_ext << 3) + (code_ext << 1) - A_W'(1 << ADC_BITS);
  assign b_init   = B_W'(p_max_q) - B_W'(p_min_q);

  // Shift-add step; the multiplier's top bit carries negative weight.
  assign mlast  = mcnt_q == MCNT_W'(A_W - 1);
  assign b_ext  = MS_W'(b_q);
  assign addend = lo_q[0] ? (mlast ? -b_ext : b_ext) : '0;
  assign msum   = MS_W'(hi_q) + addend;

  // Round half up at the converter scale and add the offset in 1/16 Pa.
  assign prod     = {hi_q, lo_q};
  assign rnd      = prod[P_W-1:ADC_BITS-2] + SHR_W'(1);
  assign rnd_half = rnd[SHR_W-1:1];
  assign p_new    = P_Q4_W'(rnd_half) + (P_Q4_W'(p_min_q) <<< 4);

  // Calibration accumulation; a zero sample count acts as one.
  assign sum_new    = sum_q + SUM_W'(p_q);
  assign cnt_new    = cnt_q + 1'b1;
  assign cal_target = (cal_cnt_cfg_q == '0) ? CNT_W'(1) : cal_cnt_cfg_q;
  assign cal_latch  = cnt_new >= cal_target;
  assign sum_mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Bias-corrected pressure, saturated, and its magnitude.
  assign diff = DIFF_W'(p_q) - DIFF_W'(bias_q);
  always_comb begin
    if (diff > DIFF_W'(DP_MAX)) begin
      dp_sat = DP_W'(DP_MAX);
    end else if (diff < DIFF_W'(DP_MIN)) begin
      dp_sat = DP_W'(DP_MIN);
    end else begin
      dp_sat = DP_W'(diff);
    end
  end
  assign dp_mag      = dp_sat[DP_W-1] ? DP_W'(-dp_sat) : DP_W'(dp_sat);
  assign density_eff = (density_q == '0) ? DVS_W'(1) : DVS_W'(density_q);

  // Mean and root results with the stored sign.
  assign q_cut    = DP_W'(div_quotient);
  assign bias_new = sign_q ? -q_cut : q_cut;
  assign root_ext = SPD_W'(sqrt_root);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    mcnt_d       = mcnt_q;
    bias_d       = bias_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    mode_d       = mode_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    b_d          = b_q;
    p_d          = p_q;
    sign_d       = sign_q;
    res_speed_d  = res_speed_q;
    res_dp_d     = res_dp_q;
    res_status_d = res_status_q;
    out_speed_d  = out_speed_q;
    out_dp_d     = out_dp_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    div_start    = 1'b0;
    div_dividend = {dp_mag, SPD_FRAC'(0)};
    div_divisor  = density_eff;
    sqrt_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          mode_d = in_i.mode;
          if (in_i.ref_code == '0) begin
            res_speed_d  = '0;
            res_dp_d     = '0;
            res_status_d = ST_ZERO_REF;
            state_d      = S_OUT;
          end else begin
            lo_d    = a_init;
            hi_d    = '0;
            b_d     = b_init;
            mcnt_d  = '0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        hi_d   = msum[MS_W-1:1];
        lo_d   = {msum[0], lo_q[A_W-1:1]};
        mcnt_d = mcnt_q + 1'b1;
        if (mlast) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        p_d     = p_new;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        res_speed_d = '0;
        if (mode_q) begin
          sum_d = sum_new;
          cnt_d = cnt_new;
          if (cal_latch) begin
            state_d = S_PREP;
          end else begin
            res_dp_d     = DP_W'(p_q);
            res_status_d = ST_CAL_SAMPLE;
            state_d      = S_OUT;
          end
        end else begin
          res_dp_d     = dp_sat;
          res_status_d = ST_MEASURED;
          div_start    = 1'b1;
          state_d      = S_DIV;
        end
      end
      S_PREP: begin
        // Mean rounded to nearest, ties away from zero, over the actual count.
        div_dividend = DIV_W'(sum_mag) + DIV_W'(cnt_q >> 1);
        div_divisor  = DVS_W'(cnt_q);
        div_start    = 1'b1;
        sign_d       = sum_q[SUM_W-1];
        sum_d        = '0;
        cnt_d        = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (mode_q) begin
            bias_d       = bias_new;
            res_dp_d     = bias_new;
            res_status_d = ST_BIAS_LATCHED;
            state_d      = S_OUT;
          end else if (|div_quotient[DIV_W-1:SQ_IN_W]) begin
            // The root would not fit: saturate the speed.
            res_speed_d = res_dp_q[DP_W-1] ? -SPD_W'(SPD_MAX) : SPD_W'(SPD_MAX);
            state_d     = S_OUT;
          end else begin
            sqrt_start = 1'b1;
            state_d    = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          res_speed_d = res_dp_q[DP_W-1] ? -root_ext : root_ext;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_speed_d  = res_speed_q;
          out_dp_d     = res_dp_q;
          out_status_d = res_status_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcnt_q      <= '0;
      bias_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mcnt_q      <= mcnt_d;
      bias_q      <= bias_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    b_q          <= b_d;
    p_q          <= p_d;
    sign_q       <= sign_d;
    res_speed_q  <= res_speed_d;
    res_dp_q     <= res_dp_d;
    res_status_q <= res_status_d;
    out_speed_q  <= out_speed_d;
    out_dp_q     <= out_dp_d;
    out_status_q <= out_status_d;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_min_q       <= PA_W'(P_MIN_RST);
      p_max_q       <= PA_W'(P_MAX_RST);
      density_q     <= DEN_W'(DEN_RST);
      cal_cnt_cfg_q <= CNT_W'(CNT_RST);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_P_MIN:   p_min_q       <= cfg_i.data[PA_W-1:0];
        REG_P_MAX:   p_max_q       <= cfg_i.data[PA_W-1:0];
        REG_DENSITY: density_q     <= cfg_i.data[DEN_W-1:0];
        REG_CAL_CNT: cal_cnt_cfg_q <= cfg_i.data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Shared divider for the bias mean and the speed quotient.
  pas_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // Square root of the speed quotient.
  pas_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quotient[SQ_IN_W-1:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // Channel outputs.
  assign in_i.ready             = (state_q == S_IDLE);
  assign cfg_i.ready            = 1'b1;
  assign out_o.valid            = out_valid_q;
  assign out_o.air_speed_q8     = out_speed_q;
  assign out_o.diff_pressure_q4 = out_dp_q;
  assign out_o.status           = out_status_q;

endmodule

>>> bench/airspeed_result_checker.sv
// Result checker for the pitot airspeed unit: watches the sample, result and settings channels.
// Keeps its own copy of the settings and calibration state and compares every result beat.
// Depends on pas_pkg and the channel interfaces pas_in_if, pas_out_if and pas_cfg_if.
module airspeed_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pas_in_if    in_ch,
  pas_out_if   out_ch,
  pas_cfg_if   cfg_ch,
  output int   mismatch_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pas_pkg::*;

  // One expected result beat.
  typedef struct {
    logic signed [SPD_W-1:0] speed;
    logic signed [DP_W-1:0]  dp;
    status_e                 status;
  } airspeed_result_t;

  airspeed_result_t expected_results[$];

  // Settings as last written.
  logic signed [PA_W-1:0] p_min_pa;
  logic signed [PA_W-1:0] p_max_pa;
  logic [DEN_W-1:0]       density_q10;
  logic [CNT_W-1:0]       cal_target;

  // Calibration state.
  longint                 bias_q4;
  longint                 cal_sum;
  int unsigned            cal_n;
  int                     fails;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Sensor pressure in 1/16 Pa; the reference code cancels out.
  function automatic longint sample_pressure(logic [CODE_W-1:0] code);
    longint span;
    longint num;
    span = longint'(p_max_pa) - longint'(p_min_pa);
    num  = (10 * longint'(code) - (longint'(1) << ADC_BITS)) * span * 2;
    return longint'(p_min_pa) * 16 + ((num + (longint'(1) << (ADC_BITS - 1))) >>> ADC_BITS);
  endfunction

  // Floor of the square root, one result bit per step.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Works out the result of one sample and advances the calibration state.
  function automatic airspeed_result_t predict_airspeed(logic calib, logic [CODE_W-1:0] rc,
                                                        logic [CODE_W-1:0] sc);
    airspeed_result_t r;
    longint           p;
    longint           d;
    longint           q;
    longint unsigned  mag;
    longint unsigned  den;
    longint unsigned  v;
    int unsigned      target;
    r.speed = '0;
    r.dp    = '0;
    if (rc == '0) begin
      r.status = ST_ZERO_REF;
    end else if (calib) begin
      p      = sample_pressure(sc);
      target = (cal_target == '0) ? 1 : 32'(cal_target);
      cal_sum += p;
      cal_n  = (cal_n + 1) & ((1 << CNT_W) - 1);
      if (cal_n >= target) begin
        // Mean rounded to nearest, ties away from zero.
        mag     = (cal_sum < 0) ? -cal_sum : cal_sum;
        q       = longint'((mag + cal_n / 2) / cal_n);
        bias_q4 = clamp((cal_sum < 0) ? -q : q, DP_MIN, DP_MAX);
        cal_sum = 0;
        cal_n   = 0;
        r.dp     = DP_W'(bias_q4);
        r.status = ST_BIAS_LATCHED;
      end else begin
        r.dp     = DP_W'(clamp(p, DP_MIN, DP_MAX));
        r.status = ST_CAL_SAMPLE;
      end
    end else begin
      den = 64'(density_q10);
      if (den == 0) den = 1;
      d   = clamp(sample_pressure(sc) - bias_q4, DP_MIN, DP_MAX);
      mag = (d < 0) ? -d : d;
      v   = root_floor((mag << SPD_FRAC) / den);
      if (v > SPD_MAX) v = SPD_MAX;
      r.speed  = SPD_W'((d < 0) ? -longint'(v) : longint'(v));
      r.dp     = DP_W'(d);
      r.status = ST_MEASURED;
    end
    return r;
  endfunction

  // Follow settings writes, queue predictions for accepted samples and check result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    airspeed_result_t want;
    if (!rst_ni) begin
      p_min_pa    = PA_W'(P_MIN_RST);
      p_max_pa    = PA_W'(P_MAX_RST);
      density_q10 = DEN_W'(DEN_RST);
      cal_target  = CNT_W'(CNT_RST);
      bias_q4     = 0;
      cal_sum     = 0;
      cal_n       = 0;
      fails       = 0;
      expected_results.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_P_MIN:   p_min_pa    = cfg_ch.data[PA_W-1:0];
          REG_P_MAX:   p_max_pa    = cfg_ch.data[PA_W-1:0];
          REG_DENSITY: density_q10 = cfg_ch.data[DEN_W-1:0];
          REG_CAL_CNT: cal_target  = cfg_ch.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_airspeed(in_ch.mode, in_ch.ref_code,
                                                    in_ch.sensor_code));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no sample outstanding: speed %0d, dp %0d, status %0d",
                 out_ch.air_speed_q8, out_ch.diff_pressure_q4, out_ch.status);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.air_speed_q8 !== want.speed) begin
            $error("air_speed_q8 mismatch: expected %0d, got %0d", want.speed,
                   out_ch.air_speed_q8);
            fails++;
          end
          if (out_ch.diff_pressure_q4 !== want.dp) begin
            $error("diff_pressure_q4 mismatch: expected %0d, got %0d", want.dp,
                   out_ch.diff_pressure_q4);
            fails++;
          end
          if (out_ch.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_ch.status);
            fails++;
          end
        end
      end
      mismatch_count_o <= fails;
      outstanding_o    <= expected_results.size();
    end
  end

endmodule

>>> bench/pitot_airspeed_from_adc_unit_tb.sv
// Top of the pitot airspeed unit testbench: clock, reset, sample and settings stimulus, verdict.
// Depends on pas_pkg, the channel interfaces, the unit and airspeed_result_checker.
module pitot_airspeed_from_adc_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pas_pkg::*;

  localparam logic MODE_MEASURE  = 1'b0;
  localparam logic MODE_CALIB    = 1'b1;
  localparam int   RANDOM_PHASES = 8;
  localparam int   PHASE_ITEMS   = 175;
  localparam int   SETTLE_CYCLES = 150;
  localparam int   HOLD_CYCLES   = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatches;
  int   outstanding;
  logic calm;
  logic hold_req;

  pas_in_if  in_ch ();
  pas_out_if out_ch ();
  pas_cfg_if cfg_ch ();

  pitot_airspeed_from_adc_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  airspeed_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .cfg_ch           (cfg_ch),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle stretch length: mostly none or short, a few long; none at all while calm.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offers one sample beat, after an optional gap, and waits for it to be taken.
  task automatic offer_sample(logic mode, logic [CODE_W-1:0] rc, logic [CODE_W-1:0] sc);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.ref_code    <= rc;
    in_ch.sensor_code <= sc;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Random sample: mostly realistic codes, with extremes and the odd zero reference.
  task automatic offer_random_sample(int calib_pct);
    logic              mode;
    logic [CODE_W-1:0] rc;
    logic [CODE_W-1:0] sc;
    int                r;
    mode = ($urandom_range(0, 99) < calib_pct) ? MODE_CALIB : MODE_MEASURE;
    r = $urandom_range(0, 99);
    if (r < 4) rc = '0;
    else if (r < 14) rc = '1;
    else if (r < 19) rc = CODE_W'(1);
    else rc = CODE_W'($urandom_range(1, 4095));
    r = $urandom_range(0, 99);
    if (r < 8) sc = '0;
    else if (r < 16) sc = '1;
    else if (r < 60) sc = CODE_W'($urandom_range(0, 4095));
    else sc = CODE_W'($urandom_range(1800, 2300));
    offer_sample(mode, rc, sc);
  endtask

  // Lowers the sample valid and waits until every result has come, plus the unit's latency.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  // Writes all four settings back to back; only called with the unit idle.
  task automatic write_settings(logic [CFG_DAT_W-1:0] p_min, logic [CFG_DAT_W-1:0] p_max,
                                logic [CFG_DAT_W-1:0] density, logic [CFG_DAT_W-1:0] count);
    write_reg(REG_P_MIN, p_min);
    write_reg(REG_P_MAX, p_max);
    write_reg(REG_DENSITY, density);
    write_reg(REG_CAL_CNT, count);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, and one long hold-off once it is asked for.
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        stall = idle_cycles();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Sample and settings stimulus, then the verdict.
  initial begin
    logic [CFG_DAT_W-1:0] lo;
    logic [CFG_DAT_W-1:0] hi;
    logic [CFG_DAT_W-1:0] den;
    logic [CFG_DAT_W-1:0] cnt;
    int                   k;
    calm     = 1'b0;
    hold_req = 1'b0;
    rst_ni   = 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_MEASURE;
    in_ch.ref_code    <= '0;
    in_ch.sensor_code <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_P_MIN;
    cfg_ch.data       <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings and zero bias: zero references in both modes, code extremes,
    // the sign change around zero pressure, and two calibration samples.
    offer_sample(MODE_MEASURE, 12'd0, 12'd2048);
    offer_sample(MODE_CALIB, 12'd0, 12'd4095);
    offer_sample(MODE_MEASURE, 12'd4095, 12'd0);
    offer_sample(MODE_MEASURE, 12'd1, 12'd4095);
    offer_sample(MODE_MEASURE, 12'd4095, 12'd410);
    offer_sample(MODE_MEASURE, 12'd2048, 12'd3686);
    offer_sample(MODE_MEASURE, 12'd3000, 12'd2048);
    offer_sample(MODE_MEASURE, 12'd3000, 12'd2047);
    offer_sample(MODE_CALIB, 12'd4095, 12'd0);
    offer_sample(MODE_CALIB, 12'd4095, 12'd4095);
    drain_results();

    // Widest span, zero density and a zero sample count, which also lowers the target
    // below the samples already taken.
    write_settings(18'h20000, 18'h1FFFF, 18'h3F000, 18'h3FC00);
    offer_sample(MODE_CALIB, 12'd4095, 12'd1000);
    offer_sample(MODE_MEASURE, 12'd4095, 12'd4095);
    offer_sample(MODE_MEASURE, 12'd4095, 12'd0);
    offer_sample(MODE_CALIB, 12'd4095, 12'd0);
    offer_sample(MODE_MEASURE, 12'd2000, 12'd2048);
    drain_results();

    // Inverted span to latch a large negative bias, then measure against it.
    write_settings(18'h1FFFF, 18'h20000, 18'h00FFF, 18'h00002);
    offer_sample(MODE_CALIB, 12'd4095, 12'd4095);
    offer_sample(MODE_CALIB, 12'd4095, 12'd4095);
    offer_sample(MODE_MEASURE, 12'd4095, 12'd0);
    drain_results();
    write_settings(18'h20000, 18'h1FFFF, 18'h3F000, 18'h3FC05);
    offer_sample(MODE_MEASURE, 12'd4095, 12'd4095);
    offer_sample(MODE_MEASURE, 12'd4095, 12'd0);
    drain_results();

    // Random phases, each under its own settings.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          lo = 18'h20000; hi = 18'h1FFFF; den = 18'h00FFF; cnt = 18'h00001;
        end
        1: begin
          lo = CFG_DAT_W'(-1500); hi = CFG_DAT_W'(2500); den = 18'h3F000; cnt = 18'h3FFFF;
        end
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            k  = $urandom_range(100, 7000);
            lo = CFG_DAT_W'(-k);
            hi = CFG_DAT_W'(k);
          end else begin
            lo = CFG_DAT_W'($urandom);
            hi = CFG_DAT_W'($urandom);
          end
          if ($urandom_range(0, 9) == 0) den = {6'($urandom), 12'd0};
          else den = {6'($urandom), 12'($urandom_range(64, 4095))};
          if (ph == 2) cnt = {8'($urandom), 10'($urandom_range(20, 60))};
          else cnt = {8'($urandom), 10'($urandom_range(1, 12))};
        end
      endcase
      write_settings(lo, hi, den, cnt);

      // One phase runs without gaps while the result side holds off for a long stretch.
      calm = (ph == 3);
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (outstanding != 0) @(posedge clk_i);
        end
        offer_random_sample((ph == 1) ? 90 : 30);
      end
      calm = 1'b0;
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("pitot_airspeed_from_adc_unit regression: pass");
    end else begin
      $display("pitot_airspeed_from_adc_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("pitot_airspeed_from_adc_unit regression: fail");
    $finish;
  end

endmodule
